@@ hw/rtl/pri_pkg.sv @@
// ----------------------------------------------------------------------------
// pri_pkg - shared types and constants
// Field widths, classification thresholds and the request that passes from
// the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package pri_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP     = 2'd2;

    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd600;
    localparam logic [15:0] TIME_STEP_RST     = 16'd0;

    // 121*(A^2+B^2) thresholds for cutoff (s >= 4) and clamp (s < 2.5)
    localparam logic [51:0] CUTOFF_T = 52'(102400) << 32;
    localparam logic [51:0] CLAMP_T  = 52'(40000) << 32;

    // (4/2.5)^2 in Q30, used below the clamp distance
    localparam logic [31:0] CLAMPED_R = 32'd2748779069;

    // 25 * 2^54, numerator of (4/s)^2
    localparam logic [58:0] R_NUM = 59'(25) << 54;

    // classified request handed from front to back
    typedef struct packed {
        logic        far;     // out of range
        logic        clamp;   // distance below the clamp
        logic        coinc;   // coincident particles
        logic        neg_x;
        logic        neg_y;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [28:0] dvs;     // floor(T / 2^20)
        logic [32:0] sqsum;   // dx^2 + dy^2
    } pair_req_t;

    typedef struct packed {
        logic      valid;
        pair_req_t data;
    } queue_head_t;

endpackage

@@ hw/rtl/pri_if.sv @@
// ----------------------------------------------------------------------------
// pri_if - request channels
// Valid/ready channels for particle pairs in and impulses out.
// ----------------------------------------------------------------------------
interface pri_pair_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface pri_impulse_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] impulse_x;
    logic signed [31:0] impulse_y;
    logic               in_range;

    modport source (output valid, impulse_x, impulse_y, in_range, input ready);
    modport sink   (input valid, impulse_x, impulse_y, in_range, output ready);
endinterface

@@ hw/rtl/pair_repulsion_impulse.sv @@
// Throughput: one pair per cycle unless stalled by a full queue or by impulse
// ready held low; the front, queue and back pipeline each advance one stage a
// cycle while enabled, with bit-per-stage dividers and root.
// Reset: asynchronous active-low rst_n empties the pipeline and the queue and
// sets screen 800 x 600 and a zero time step.
// ----------------------------------------------------------------------------
// pair_repulsion_impulse - short-range pair repulsion
// Top level: configuration registers, classifying front end, request queue
// and impulse back end.
// ----------------------------------------------------------------------------
module pair_repulsion_impulse
    import pri_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pri_pair_if.sink      pair,
    pri_impulse_if.source impulse,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [15:0] time_step_reg;

    logic        push;
    pair_req_t   push_data;
    logic        pop;
    logic        queue_full;
    queue_head_t head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            time_step_reg     <= TIME_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                CFG_TIME_STEP:     time_step_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    pri_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair          (pair),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    pri_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    pri_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .time_step (time_step_reg),
        .impulse   (impulse)
    );

endmodule

@@ hw/rtl/pri_div.sv @@
// ----------------------------------------------------------------------------
// pri_div - pipelined restoring divider
// 59-bit numerator by 29-bit divisor, 32 quotient bits, one bit per stage.
// The upper 27 numerator bits must be below the divisor.
// ----------------------------------------------------------------------------
module pri_div
    import pri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [58:0] num,
    input  logic [28:0] den,
    output logic        out_valid,
    output logic [31:0] quo
);

    logic        vld_reg  [0:31];
    logic [28:0] rem_reg  [0:31];
    logic [31:0] low_reg  [0:31];
    logic [31:0] quo_reg  [0:31];
    logic [28:0] den_reg  [0:31];

    logic        vld_src  [0:31];
    logic [28:0] rem_src  [0:31];
    logic [31:0] low_src  [0:31];
    logic [31:0] quo_src  [0:31];
    logic [28:0] den_src  [0:31];

    logic [28:0] rem_next [0:31];
    logic [31:0] quo_next [0:31];

    // stage inputs
    always_comb
    begin
        vld_src[0] = in_valid;
        rem_src[0] = {2'b00, num[58:32]};
        low_src[0] = num[31:0];
        quo_src[0] = '0;
        den_src[0] = den;
        for (int k = 1; k < 32; k++)
        begin
            vld_src[k] = vld_reg[k-1];
            rem_src[k] = rem_reg[k-1];
            low_src[k] = low_reg[k-1];
            quo_src[k] = quo_reg[k-1];
            den_src[k] = den_reg[k-1];
        end
    end

    // one trial subtraction per stage
    always_comb
    begin
        logic [29:0] trial;
        logic [29:0] diff;
        logic        ge;
        for (int k = 0; k < 32; k++)
        begin
            trial       = {rem_src[k], low_src[k][31]};
            diff        = trial - {1'b0, den_src[k]};
            ge          = trial >= {1'b0, den_src[k]};
            rem_next[k] = ge ? diff[28:0] : trial[28:0];
            quo_next[k] = {quo_src[k][30:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 32; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < 32; k++)
                vld_reg[k] <= vld_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 32; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_src[k][30:0], 1'b0};
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_src[k];
            end
        end
    end

    assign out_valid = vld_reg[31];
    assign quo       = quo_reg[31];

endmodule

@@ hw/rtl/pri_sqrt.sv @@
// ----------------------------------------------------------------------------
// pri_sqrt - pipelined integer square root
// floor(sqrt) of a 58-bit radicand, one root bit per stage, 29 stages.
// ----------------------------------------------------------------------------
module pri_sqrt
    import pri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [57:0] rad,
    output logic        out_valid,
    output logic [28:0] root
);

    logic        vld_reg  [0:28];
    logic [30:0] rem_reg  [0:28];
    logic [57:0] rad_reg  [0:28];
    logic [28:0] root_reg [0:28];

    logic        vld_src  [0:28];
    logic [30:0] rem_src  [0:28];
    logic [57:0] rad_src  [0:28];
    logic [28:0] root_src [0:28];

    logic [30:0] rem_next  [0:28];
    logic [28:0] root_next [0:28];

    always_comb
    begin
        vld_src[0]  = in_valid;
        rem_src[0]  = '0;
        rad_src[0]  = rad;
        root_src[0] = '0;
        for (int k = 1; k < 29; k++)
        begin
            vld_src[k]  = vld_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
    end

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        logic [32:0] trial;
        logic [32:0] cand;
        logic [32:0] diff;
        logic        ge;
        for (int k = 0; k < 29; k++)
        begin
            trial        = {rem_src[k], rad_src[k][57:56]};
            cand         = {2'b00, root_src[k], 2'b01};
            diff         = trial - cand;
            ge           = trial >= cand;
            rem_next[k]  = ge ? diff[30:0] : trial[30:0];
            root_next[k] = {root_src[k][27:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 29; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < 29; k++)
                vld_reg[k] <= vld_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 29; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= {rad_src[k][55:0], 2'b00};
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = vld_reg[28];
    assign root      = root_reg[28];

endmodule

@@ hw/rtl/pri_front.sv @@
// ----------------------------------------------------------------------------
// pri_front - pair intake and classification
// Four stages: differences, pixel scaling, squares, distance measure; the
// result is classified and pushed into the queue.
// ----------------------------------------------------------------------------
module pri_front
    import pri_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    pri_pair_if.sink        pair,
    input  logic [12:0]     screen_width,
    input  logic [12:0]     screen_height,
    input  logic            queue_full,
    output logic            push,
    output pair_req_t       push_data
);

    logic        fe;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0] mx1_reg, my1_reg, mx2_reg, my2_reg, mx3_reg, my3_reg, mx4_reg, my4_reg;
    logic        nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg, nx4_reg, ny4_reg;
    logic [28:0] a2_reg, b2_reg;
    logic [31:0] mxx2_reg, myy2_reg;
    logic        far3_reg, far4_reg;
    logic [43:0] aa3_reg, bb3_reg;
    logic [32:0] sq3_reg, sq4_reg;
    logic [51:0] t4_reg;

    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic [44:0]        ab_sum;

    // the front moves whenever its last stage can leave
    assign fe         = !v4_reg || !queue_full;
    assign pair.ready = fe;
    assign push       = v4_reg && !queue_full;

    assign dx  = {pair.second_x[15], pair.second_x} - {pair.first_x[15], pair.first_x};
    assign dy  = {pair.second_y[15], pair.second_y} - {pair.first_y[15], pair.first_y};
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);

    assign ab_sum = {1'b0, aa3_reg} + {1'b0, bb3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= pair.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            // differences
            mx1_reg  <= adx[15:0];
            my1_reg  <= ady[15:0];
            nx1_reg  <= dx[16];
            ny1_reg  <= dy[16];
            // pixel scaling and length squares
            a2_reg   <= 29'(mx1_reg) * 29'(screen_width);
            b2_reg   <= 29'(my1_reg) * 29'(screen_height);
            mxx2_reg <= 32'(mx1_reg) * 32'(mx1_reg);
            myy2_reg <= 32'(my1_reg) * 32'(my1_reg);
            mx2_reg  <= mx1_reg;
            my2_reg  <= my1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            // pixel squares
            far3_reg <= (a2_reg[28:22] != '0) || (b2_reg[28:22] != '0);
            aa3_reg  <= 44'(a2_reg[21:0]) * 44'(a2_reg[21:0]);
            bb3_reg  <= 44'(b2_reg[21:0]) * 44'(b2_reg[21:0]);
            sq3_reg  <= {1'b0, mxx2_reg} + {1'b0, myy2_reg};
            mx3_reg  <= mx2_reg;
            my3_reg  <= my2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            // scaled distance measure
            t4_reg   <= 52'(ab_sum) * 52'd121;
            far4_reg <= far3_reg;
            sq4_reg  <= sq3_reg;
            mx4_reg  <= mx3_reg;
            my4_reg  <= my3_reg;
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
        end
    end

    // classification
    always_comb
    begin
        push_data.far   = far4_reg || (t4_reg >= CUTOFF_T);
        push_data.clamp = t4_reg < CLAMP_T;
        push_data.coinc = (mx4_reg == '0) && (my4_reg == '0);
        push_data.neg_x = nx4_reg;
        push_data.neg_y = ny4_reg;
        push_data.mag_x = mx4_reg;
        push_data.mag_y = my4_reg;
        push_data.dvs   = t4_reg[48:20];
        push_data.sqsum = sq4_reg;
    end

endmodule

@@ hw/rtl/pri_queue.sv @@
// ----------------------------------------------------------------------------
// pri_queue - request queue between front and back
// Four-entry queue; head is shown with its valid flag.
// ----------------------------------------------------------------------------
module pri_queue
    import pri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pair_req_t   push_data,
    input  logic        pop,
    output logic        full,
    output queue_head_t head
);

    pair_req_t   mem [0:3];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    assign full       = count_reg[2];
    assign head.valid = count_reg != '0;
    assign head.data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hw/rtl/pri_back.sv @@
// ----------------------------------------------------------------------------
// pri_back - force and impulse pipeline
// Divides for (4/s)^2 while the length root runs alongside, raises to the
// twelfth power, scales by the time step and projects onto both axes.
// ----------------------------------------------------------------------------
module pri_back
    import pri_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_head_t   head,
    output logic          pop,
    input  logic [15:0]   time_step,
    pri_impulse_if.source impulse
);

    typedef struct packed {
        logic        far;
        logic        clamp;
        logic        coinc;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
    } side_a_t;

    typedef struct packed {
        logic        far;
        logic        coinc;
        logic        neg_x;
        logic        neg_y;
        logic [30:0] m;
    } side_b_t;

    logic        be;

    side_a_t     sa_reg  [0:31];
    side_b_t     sb_reg  [0:31];
    logic [28:0] lpad_reg [0:2];

    logic        rv;
    logic [31:0] rq;
    logic        sv;
    logic [28:0] sroot;

    logic        p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    side_a_t     p1_s_reg, p2_s_reg, p3_s_reg, p4_s_reg;
    logic [28:0] p1_l_reg, p2_l_reg, p3_l_reg, p4_l_reg, p5_l_reg;
    logic [26:0] p1_r2_reg, p2_r2_reg;
    logic [29:0] p2_r4_reg;
    logic [32:0] p3_f_reg;
    logic [30:0] p4_m_reg;
    side_b_t     p5_s_reg;
    logic [46:0] p5_px_reg, p5_py_reg;

    logic [31:0] r_sel;
    logic [63:0] rr;
    logic [53:0] r2r2;
    logic [56:0] r4r2;
    logic [48:0] fts;

    logic        xv, yv;
    logic [31:0] qx, qy;

    logic        out_v_reg;
    logic [31:0] ix, iy;
    logic [31:0] out_x_reg, out_y_reg;
    logic        out_r_reg;

    // the back moves whenever the output register can take a result
    assign be  = !out_v_reg || impulse.ready;
    assign pop = be && head.valid;

    // (4/s)^2 in Q30
    pri_div u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (be),
        .in_valid  (head.valid),
        .num       (R_NUM),
        .den       (head.data.dvs),
        .out_valid (rv),
        .quo       (rq)
    );

    // length in Q12
    pri_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (be),
        .in_valid  (head.valid),
        .rad       ({1'b0, head.data.sqsum, 24'd0}),
        .out_valid (sv),
        .root      (sroot)
    );

    // side data riding along the first divide
    always_ff @(posedge clk)
    begin
        if (be)
        begin
            sa_reg[0].far   <= head.data.far;
            sa_reg[0].clamp <= head.data.clamp;
            sa_reg[0].coinc <= head.data.coinc;
            sa_reg[0].neg_x <= head.data.neg_x;
            sa_reg[0].neg_y <= head.data.neg_y;
            sa_reg[0].mag_x <= head.data.mag_x;
            sa_reg[0].mag_y <= head.data.mag_y;
            for (int k = 1; k < 32; k++)
                sa_reg[k] <= sa_reg[k-1];
            lpad_reg[0] <= sroot;
            lpad_reg[1] <= lpad_reg[0];
            lpad_reg[2] <= lpad_reg[1];
        end
    end

    // twelfth power and time step scaling
    assign r_sel = sa_reg[31].clamp ? CLAMPED_R : rq;
    assign rr    = 64'(r_sel) * 64'(r_sel);
    assign r2r2  = 54'(p1_r2_reg) * 54'(p1_r2_reg);
    assign r4r2  = 57'(p2_r4_reg) * 57'(p2_r2_reg);
    assign fts   = 49'(p3_f_reg) * 49'(time_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else if (be)
        begin
            p1_v_reg <= rv;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            p1_r2_reg <= rr[62:36];
            p1_s_reg  <= sa_reg[31];
            p1_l_reg  <= lpad_reg[2];
            p2_r4_reg <= r2r2[53:24];
            p2_r2_reg <= p1_r2_reg;
            p2_s_reg  <= p1_s_reg;
            p2_l_reg  <= p1_l_reg;
            p3_f_reg  <= r4r2[56:24];
            p3_s_reg  <= p2_s_reg;
            p3_l_reg  <= p2_l_reg;
            p4_m_reg  <= fts[48:18];
            p4_s_reg  <= p3_s_reg;
            p4_l_reg  <= p3_l_reg;
            // projection numerators
            p5_px_reg      <= 47'(p4_m_reg) * 47'(p4_s_reg.mag_x);
            p5_py_reg      <= 47'(p4_m_reg) * 47'(p4_s_reg.mag_y);
            p5_l_reg       <= p4_l_reg;
            p5_s_reg.far   <= p4_s_reg.far;
            p5_s_reg.coinc <= p4_s_reg.coinc;
            p5_s_reg.neg_x <= p4_s_reg.neg_x;
            p5_s_reg.neg_y <= p4_s_reg.neg_y;
            p5_s_reg.m     <= p4_m_reg;
        end
    end

    // m * |d| / L on each axis
    pri_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (be),
        .in_valid  (p5_v_reg),
        .num       ({p5_px_reg, 12'd0}),
        .den       (p5_l_reg),
        .out_valid (xv),
        .quo       (qx)
    );

    pri_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (be),
        .in_valid  (p5_v_reg),
        .num       ({p5_py_reg, 12'd0}),
        .den       (p5_l_reg),
        .out_valid (yv),
        .quo       (qy)
    );

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            sb_reg[0] <= p5_s_reg;
            for (int k = 1; k < 32; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // special cases: out of range gives zero, coincident pushes along +x
    always_comb
    begin
        if (sb_reg[31].far)
        begin
            ix = '0;
            iy = '0;
        end
        else if (sb_reg[31].coinc)
        begin
            ix = {1'b0, sb_reg[31].m};
            iy = '0;
        end
        else
        begin
            ix = qx;
            iy = qy;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (be)
            out_v_reg <= xv && yv;
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            out_x_reg <= sb_reg[31].neg_x ? 32'(-ix) : ix;
            out_y_reg <= sb_reg[31].neg_y ? 32'(-iy) : iy;
            out_r_reg <= (ix != '0) || (iy != '0);
        end
    end

    assign impulse.valid     = out_v_reg;
    assign impulse.impulse_x = out_x_reg;
    assign impulse.impulse_y = out_y_reg;
    assign impulse.in_range  = out_r_reg;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - pair repulsion impulse testbench
// Drives particle pairs through the valid/ready channel with random gaps,
// predicts each impulse with an integer model of the fixed-point arithmetic,
// and compares every impulse request field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import pri_pkg::*;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] ix;
        logic signed [31:0] iy;
        logic               hit;
    } impulse_t;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SCREEN_WIDTH;
    logic [15:0] cfg_data = '0;

    pri_pair_if    pair ();
    pri_impulse_if impulse ();

    pair_repulsion_impulse i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair.sink),
        .impulse   (impulse.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor copy of the registers
    logic [63:0] scr_w = 64'd800;
    logic [63:0] scr_h = 64'd600;
    logic [63:0] tstep = 64'd0;

    pair_t    pending_pairs[$];
    impulse_t expected_impulses[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       drain_hold = 1'b0;
    int       hold_count = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic impulse_t repulsion(pair_t p);
        impulse_t o;
        int dx, dy;
        logic [63:0] mx, my, a, b, t, r, r2, r4, f, m, len, ix, iy;
        dx = int'(p.sx) - int'(p.fx);
        dy = int'(p.sy) - int'(p.fy);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        a = mx * scr_w;
        b = my * scr_h;
        o = '0;
        if (a >= (64'd1 << 22) || b >= (64'd1 << 22)) return o;
        t = 64'd121 * (a * a + b * b);
        if (t >= (64'd102400 << 32)) return o;
        if (t < (64'd40000 << 32)) r = 64'd2748779069;
        else r = (64'd25 << 54) / (t >> 20);
        r2 = (r * r) >> 36;
        r4 = (r2 * r2) >> 24;
        f = (r4 * r2) >> 24;
        m = (f * tstep) >> 18;
        // coincident pair pushes along +x
        if (mx == 0 && my == 0)
        begin
            ix = m;
            iy = 0;
        end
        else
        begin
            len = int_sqrt((mx * mx + my * my) << 24);
            ix = ((m * mx) << 12) / len;
            iy = ((m * my) << 12) / len;
        end
        o.ix = (dx < 0) ? -ix[31:0] : ix[31:0];
        o.iy = (dy < 0) ? -iy[31:0] : iy[31:0];
        o.hit = (ix != 0 || iy != 0);
        return o;
    endfunction

    // pair driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair.valid <= 1'b0;
            pair.first_x <= '0;
            pair.first_y <= '0;
            pair.second_x <= '0;
            pair.second_y <= '0;
        end
        else
        begin
            if (pair.valid && pair.ready)
                expected_impulses.push_back(repulsion({pair.first_x, pair.first_y,
                                                       pair.second_x, pair.second_y}));
            if (!pair.valid || pair.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    pair.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    pair.valid <= 1'b1;
                    pair.first_x <= p.fx;
                    pair.first_y <= p.fy;
                    pair.second_x <= p.sx;
                    pair.second_y <= p.sy;
                    if ($urandom_range(0, 3) == 0)
                        send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                                : $urandom_range(1, 3);
                end
                else
                    pair.valid <= 1'b0;
            end
        end
    end

    // impulse monitor and receiver stalls
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            impulse.ready <= 1'b0;
        else
        begin
            if (impulse.valid && impulse.ready)
            begin
                if (expected_impulses.size() == 0)
                begin
                    $error("impulse with nothing expected");
                    errors = errors + 1;
                end
                else
                begin
                    impulse_t e;
                    e = expected_impulses.pop_front();
                    if (impulse.impulse_x !== e.ix)
                    begin
                        $error("impulse_x expected %0d got %0d", e.ix, impulse.impulse_x);
                        errors = errors + 1;
                    end
                    if (impulse.impulse_y !== e.iy)
                    begin
                        $error("impulse_y expected %0d got %0d", e.iy, impulse.impulse_y);
                        errors = errors + 1;
                    end
                    if (impulse.in_range !== e.hit)
                    begin
                        $error("in_range expected %0d got %0d", e.hit, impulse.in_range);
                        errors = errors + 1;
                    end
                end
            end
            if (drain_hold && hold_count < 400)
            begin
                hold_count <= hold_count + 1;
                impulse.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                impulse.ready <= 1'b0;
            end
            else
            begin
                impulse.ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
            end
        end
    end

    // watchdog on accepted requests
    always @(posedge clk)
    begin
        if ((pair.valid && pair.ready) || (impulse.valid && impulse.ready) || hold_count < 400
            && drain_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && rst_n)
        begin
            $display("pair_repulsion_impulse: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  scr_w = val & 16'h1FFF;
            CFG_SCREEN_HEIGHT: scr_h = val & 16'h1FFF;
            default:           tstep = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || pair.valid || expected_impulses.size() > 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    // mostly close pairs so the force path is exercised
    function automatic pair_t near_pair(int spread);
        pair_t p;
        p.fx = 16'($urandom);
        p.fy = 16'($urandom);
        p.sx = p.fx + 16'($signed($urandom_range(0, 2 * spread)) - spread);
        p.sy = p.fy + 16'($signed($urandom_range(0, 2 * spread)) - spread);
        return p;
    endfunction

    task automatic random_phase(int count);
        pair_t p;
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 8) p = near_pair($urandom_range(1, 600));
            else p = pair_t'({$urandom, $urandom});
            pending_pairs.push_back(p);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset screen size with a time step of 40000, then extremes
        write_reg(CFG_TIME_STEP, 16'd40000);
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_pairs.push_back('{16'sd100, -16'sd50, 16'sd100, -16'sd50});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd10, 16'sd0});
        pending_pairs.push_back('{16'sd0, 16'sd0, -16'sd10, 16'sd0});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd30});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd200, 16'sd200});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd0});
        pending_pairs.push_back('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767});
        pending_pairs.push_back('{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd400, -16'sd400});
        pending_pairs.push_back('{16'sd5, 16'sd5, 16'sd4, 16'sd6});
        wait_idle();
        write_reg(CFG_TIME_STEP, 16'd0);
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd20, 16'sd20});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, 16'd0);
        write_reg(CFG_SCREEN_HEIGHT, 16'd4096);
        write_reg(CFG_TIME_STEP, 16'hFFFF);
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd30000, 16'sd5});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd7, 16'sd1});
        pending_pairs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        wait_idle();
        // random phases across settings; the receiver holds off once
        drain_hold = 1'b1;
        write_reg(CFG_SCREEN_WIDTH, 16'd800);
        write_reg(CFG_SCREEN_HEIGHT, 16'd600);
        write_reg(CFG_TIME_STEP, 16'd1000);
        random_phase(250);
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, 16'd4096);
        write_reg(CFG_SCREEN_HEIGHT, 16'd1);
        write_reg(CFG_TIME_STEP, 16'hFFFF);
        random_phase(200);
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, 16'hFFFF);
        write_reg(CFG_SCREEN_HEIGHT, 16'd0);
        write_reg(CFG_TIME_STEP, 16'd1);
        random_phase(150);
        wait_idle();
        repeat (3)
        begin
            write_reg(CFG_SCREEN_WIDTH, 16'($urandom_range(1, 4096)));
            write_reg(CFG_SCREEN_HEIGHT, 16'($urandom_range(1, 4096)));
            write_reg(CFG_TIME_STEP, 16'($urandom));
            random_phase(170);
            wait_idle();
        end
        if (errors == 0)
            $display("pair_repulsion_impulse: match");
        else
            $display("pair_repulsion_impulse: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/pri_pkg.sv
hw/rtl/pri_if.sv
hw/rtl/pri_div.sv
hw/rtl/pri_sqrt.sv
hw/rtl/pri_front.sv
hw/rtl/pri_queue.sv
hw/rtl/pri_back.sv
hw/rtl/pair_repulsion_impulse.sv
sim/tb_top.sv
